// File: rtl/ipv4_flow_key_extractor_defines.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is held off while rst_n is low.
`ifndef IPV4_FLOW_KEY_EXTRACTOR_DEFINES_SVH
`define IPV4_FLOW_KEY_EXTRACTOR_DEFINES_SVH

// Same-cycle implication.
`define IFKE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IFKE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ifke_pkg.sv
`timescale 1ns / 1ps
package ifke_pkg;

  localparam int unsigned L4_BYTES = 12;

  // IPv4 protocol numbers that carry L4 fields into the key.
  localparam logic [7:0] PROTO_ICMP    = 8'd1;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PROTO_DCCP    = 8'd33;
  localparam logic [7:0] PROTO_GRE     = 8'd47;
  localparam logic [7:0] PROTO_SCTP    = 8'd132;
  localparam logic [7:0] PROTO_UDPLITE = 8'd136;

  // Bytes needed past the IP header for each kind of L4 field.
  localparam logic [16:0] NEED_PORTS = 17'd4;
  localparam logic [16:0] NEED_ICMP  = 17'd2;
  localparam logic [16:0] NEED_GRE   = 17'd12;

  localparam logic [15:0] FRAG_MASK  = 16'h3FFF;
  localparam logic [7:0]  TOS_MASK   = 8'hFC;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // Header byte offsets.
  localparam logic [15:0] OFS_TOS    = 16'd1;
  localparam logic [15:0] OFS_FRAG_HI = 16'd6;
  localparam logic [15:0] OFS_FRAG_LO = 16'd7;
  localparam logic [15:0] OFS_PROTO  = 16'd9;

  // GRE flag bits within the first L4 byte.
  localparam int unsigned GRE_CSUM_BIT = 7;
  localparam int unsigned GRE_KEY_BIT  = 5;

  typedef logic [1:0] l4cls_t;
  localparam l4cls_t CLS_NONE  = 2'd0;
  localparam l4cls_t CLS_PORTS = 2'd1;
  localparam l4cls_t CLS_ICMP  = 2'd2;
  localparam l4cls_t CLS_GRE   = 2'd3;

  // One finished packet, as handed from the capture side to key formation.
  typedef struct packed {
    logic [31:0]               mark;
    logic [30:0]               arrival_ifx;
    logic [30:0]               route_ifx;
    logic                      swap;
    logic [7:0]                proto;
    logic [31:0]               src_addr;
    logic [31:0]               dst_addr;
    logic [7:0]                tos;
    l4cls_t                    cls;
    logic [L4_BYTES-1:0][7:0]  l4;
  } rec_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_stat_t;

endpackage

// File: rtl/ipv4_flow_key_extractor.sv
// Channel   Direction  Handshake            Moves
// in_*      input      in_valid/in_ready    one packet byte plus metadata
// out_*     output     out_valid/out_ready  one flow key per packet
//
// One byte is taken every cycle while the two-entry key queue has room.
// A key moves from the transfer of its last byte into the queue, then into the output
// register that drives out_*; while that register is held, the key waits in the queue.
// A stalled output only fills the queue; bytes keep flowing until it is full.
// rst_n is synchronous; after reset the count, captured fields and metadata are zero.
`timescale 1ns / 1ps
`include "ipv4_flow_key_extractor_defines.svh"
module ipv4_flow_key_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        in_swap_direction,
  input  logic [31:0] in_packet_mark,
  input  logic [30:0] in_arrival_ifindex,
  input  logic [30:0] in_route_ifindex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_key_mark,
  output logic [30:0] out_key_ifindex,
  output logic [7:0]  out_key_protocol,
  output logic [31:0] out_key_dst_addr,
  output logic [31:0] out_key_src_addr,
  output logic [7:0]  out_key_tos,
  output logic [15:0] out_key_src_port,
  output logic [15:0] out_key_dst_port,
  output logic [7:0]  out_key_icmp_type,
  output logic [7:0]  out_key_icmp_code,
  output logic [31:0] out_key_gre_key
);

  logic              take;
  logic              push;
  logic              pop;
  ifke_pkg::rec_t    push_rec;
  ifke_pkg::rec_t    head;
  ifke_pkg::q_stat_t q_stat;

  assign in_ready = ~q_stat.full;
  assign take     = in_valid & in_ready;

  ifke_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .take               (take),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_last_byte       (in_last_byte),
    .in_swap_direction  (in_swap_direction),
    .in_packet_mark     (in_packet_mark),
    .in_arrival_ifindex (in_arrival_ifindex),
    .in_route_ifindex   (in_route_ifindex),
    .push               (push),
    .rec                (push_rec)
  );

  ifke_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ifke_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (~q_stat.empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key_mark      (out_key_mark),
    .out_key_ifindex   (out_key_ifindex),
    .out_key_protocol  (out_key_protocol),
    .out_key_dst_addr  (out_key_dst_addr),
    .out_key_src_addr  (out_key_src_addr),
    .out_key_tos       (out_key_tos),
    .out_key_src_port  (out_key_src_port),
    .out_key_dst_port  (out_key_dst_port),
    .out_key_icmp_type (out_key_icmp_type),
    .out_key_icmp_code (out_key_icmp_code),
    .out_key_gre_key   (out_key_gre_key)
  );

  `IFKE_ASSERT_NOW(a_q_count_range, 1'b1, q_stat.count != 2'd3, "key queue count out of range")
  `IFKE_ASSERT_NEXT(a_push_lands, push, !q_stat.empty, "pushed key missing from queue")
  `IFKE_ASSERT_NEXT(a_pop_shows, pop, out_valid, "popped key not presented on output")

endmodule

// File: rtl/ifke_front.sv
`timescale 1ns / 1ps
module ifke_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    in_data_byte,
  input  logic          in_first_byte,
  input  logic          in_last_byte,
  input  logic          in_swap_direction,
  input  logic [31:0]   in_packet_mark,
  input  logic [30:0]   in_arrival_ifindex,
  input  logic [30:0]   in_route_ifindex,
  output logic          push,
  output ifke_pkg::rec_t rec
);

  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  hw_r, hw_nxt;
  logic [7:0]  tos_r, tos_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [7:0]  l4_r   [ifke_pkg::L4_BYTES];
  logic [7:0]  l4_nxt [ifke_pkg::L4_BYTES];
  logic [31:0] mark_r, mark_nxt;
  logic [30:0] arr_r, arr_nxt;
  logic [30:0] rt_r, rt_nxt;
  logic        swap_r, swap_nxt;

  logic [15:0] idx;
  logic [15:0] off;
  logic [15:0] total;
  logic [16:0] total_x;
  logic [16:0] hw_x;
  logic        frag_ok;
  ifke_pkg::l4cls_t cls;

  always_comb begin
    idx = in_first_byte ? '0 : cnt_r;

    // A first byte starts a fresh capture; otherwise fields carry over.
    hw_nxt    = in_first_byte ? '0 : hw_r;
    tos_nxt   = in_first_byte ? '0 : tos_r;
    frag_nxt  = in_first_byte ? '0 : frag_r;
    proto_nxt = in_first_byte ? '0 : proto_r;
    src_nxt   = in_first_byte ? '0 : src_r;
    dst_nxt   = in_first_byte ? '0 : dst_r;
    for (int i = 0; i < ifke_pkg::L4_BYTES; i++) begin
      l4_nxt[i] = in_first_byte ? '0 : l4_r[i];
    end
    mark_nxt = in_first_byte ? in_packet_mark     : mark_r;
    arr_nxt  = in_first_byte ? in_arrival_ifindex : arr_r;
    rt_nxt   = in_first_byte ? in_route_ifindex   : rt_r;
    swap_nxt = in_first_byte ? in_swap_direction  : swap_r;

    if (idx == '0) begin
      hw_nxt = {2'b00, in_data_byte[3:0], 2'b00};
    end else if (idx == ifke_pkg::OFS_TOS) begin
      tos_nxt = in_data_byte;
    end else if (idx == ifke_pkg::OFS_FRAG_HI) begin
      frag_nxt = {in_data_byte, frag_nxt[7:0]};
    end else if (idx == ifke_pkg::OFS_FRAG_LO) begin
      frag_nxt = {frag_nxt[15:8], in_data_byte};
    end else if (idx == ifke_pkg::OFS_PROTO) begin
      proto_nxt = in_data_byte;
    end else if (idx inside {[16'd12:16'd15]}) begin
      src_nxt = {src_nxt[23:0], in_data_byte};
    end else if (idx inside {[16'd16:16'd19]}) begin
      dst_nxt = {dst_nxt[23:0], in_data_byte};
    end

    // The L4 window uses the header length as updated by this byte.
    off = idx - {8'h00, hw_nxt};
    if ((idx >= {8'h00, hw_nxt}) && (off < 16'(ifke_pkg::L4_BYTES))) begin
      l4_nxt[off[3:0]] = in_data_byte;
    end

    total   = (idx != ifke_pkg::COUNT_MAX) ? idx + 16'd1 : idx;
    cnt_nxt = in_last_byte ? '0 : total;

    total_x = {1'b0, total};
    hw_x    = {9'h000, hw_nxt};
    frag_ok = (frag_nxt & ifke_pkg::FRAG_MASK) == '0;
    cls     = ifke_pkg::CLS_NONE;
    if (frag_ok) begin
      if (proto_nxt inside {ifke_pkg::PROTO_TCP, ifke_pkg::PROTO_UDP, ifke_pkg::PROTO_DCCP,
                            ifke_pkg::PROTO_SCTP, ifke_pkg::PROTO_UDPLITE}) begin
        if (total_x >= hw_x + ifke_pkg::NEED_PORTS) begin
          cls = ifke_pkg::CLS_PORTS;
        end
      end else if (proto_nxt == ifke_pkg::PROTO_ICMP) begin
        if (total_x >= hw_x + ifke_pkg::NEED_ICMP) begin
          cls = ifke_pkg::CLS_ICMP;
        end
      end else if (proto_nxt == ifke_pkg::PROTO_GRE) begin
        if ((total_x >= hw_x + ifke_pkg::NEED_GRE) && l4_nxt[0][ifke_pkg::GRE_KEY_BIT]) begin
          cls = ifke_pkg::CLS_GRE;
        end
      end
    end

    rec.mark        = mark_nxt;
    rec.arrival_ifx = arr_nxt;
    rec.route_ifx   = rt_nxt;
    rec.swap        = swap_nxt;
    rec.proto       = proto_nxt;
    rec.src_addr    = src_nxt;
    rec.dst_addr    = dst_nxt;
    rec.tos         = tos_nxt;
    rec.cls         = cls;
    for (int i = 0; i < ifke_pkg::L4_BYTES; i++) begin
      rec.l4[i] = l4_nxt[i];
    end
  end

  assign push = take & in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      hw_r    <= '0;
      tos_r   <= '0;
      frag_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      mark_r  <= '0;
      arr_r   <= '0;
      rt_r    <= '0;
      swap_r  <= 1'b0;
      for (int i = 0; i < ifke_pkg::L4_BYTES; i++) begin
        l4_r[i] <= '0;
      end
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      hw_r    <= hw_nxt;
      tos_r   <= tos_nxt;
      frag_r  <= frag_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      mark_r  <= mark_nxt;
      arr_r   <= arr_nxt;
      rt_r    <= rt_nxt;
      swap_r  <= swap_nxt;
      for (int i = 0; i < ifke_pkg::L4_BYTES; i++) begin
        l4_r[i] <= l4_nxt[i];
      end
    end
  end

endmodule

// File: rtl/ifke_queue.sv
`timescale 1ns / 1ps
module ifke_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ifke_pkg::rec_t   push_rec,
  input  logic             pop,
  output ifke_pkg::rec_t   head,
  output ifke_pkg::q_stat_t stat
);

  ifke_pkg::rec_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: rtl/ifke_back.sv
`timescale 1ns / 1ps
module ifke_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ifke_pkg::rec_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_key_mark,
  output logic [30:0]    out_key_ifindex,
  output logic [7:0]     out_key_protocol,
  output logic [31:0]    out_key_dst_addr,
  output logic [31:0]    out_key_src_addr,
  output logic [7:0]     out_key_tos,
  output logic [15:0]    out_key_src_port,
  output logic [15:0]    out_key_dst_port,
  output logic [7:0]     out_key_icmp_type,
  output logic [7:0]     out_key_icmp_code,
  output logic [31:0]    out_key_gre_key
);

  logic        valid_r;
  logic [31:0] mark_r;
  logic [30:0] ifx_r, ifx_nxt;
  logic [7:0]  proto_r;
  logic [31:0] dst_r, dst_nxt;
  logic [31:0] src_r, src_nxt;
  logic [7:0]  tos_r;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [7:0]  itype_r, itype_nxt;
  logic [7:0]  icode_r, icode_nxt;
  logic [31:0] gkey_r, gkey_nxt;
  logic [15:0] p0, p1;

  assign pop = q_valid & (~valid_r | out_ready);

  always_comb begin
    p0 = {head.l4[0], head.l4[1]};
    p1 = {head.l4[2], head.l4[3]};
    ifx_nxt   = head.swap ? head.arrival_ifx : head.route_ifx;
    dst_nxt   = head.swap ? head.src_addr : head.dst_addr;
    src_nxt   = head.swap ? head.dst_addr : head.src_addr;
    sport_nxt = '0;
    dport_nxt = '0;
    itype_nxt = '0;
    icode_nxt = '0;
    gkey_nxt  = '0;
    case (head.cls)
      ifke_pkg::CLS_PORTS: begin
        sport_nxt = head.swap ? p1 : p0;
        dport_nxt = head.swap ? p0 : p1;
      end
      ifke_pkg::CLS_ICMP: begin
        itype_nxt = head.l4[0];
        icode_nxt = head.l4[1];
      end
      ifke_pkg::CLS_GRE: begin
        // With the checksum present the key moves down one word.
        if (head.l4[0][ifke_pkg::GRE_CSUM_BIT]) begin
          gkey_nxt = {head.l4[8], head.l4[9], head.l4[10], head.l4[11]};
        end else begin
          gkey_nxt = {head.l4[4], head.l4[5], head.l4[6], head.l4[7]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mark_r  <= head.mark;
      ifx_r   <= ifx_nxt;
      proto_r <= head.proto;
      dst_r   <= dst_nxt;
      src_r   <= src_nxt;
      tos_r   <= head.tos & ifke_pkg::TOS_MASK;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      itype_r <= itype_nxt;
      icode_r <= icode_nxt;
      gkey_r  <= gkey_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_key_mark      = mark_r;
  assign out_key_ifindex   = ifx_r;
  assign out_key_protocol  = proto_r;
  assign out_key_dst_addr  = dst_r;
  assign out_key_src_addr  = src_r;
  assign out_key_tos       = tos_r;
  assign out_key_src_port  = sport_r;
  assign out_key_dst_port  = dport_r;
  assign out_key_icmp_type = itype_r;
  assign out_key_icmp_code = icode_r;
  assign out_key_gre_key   = gkey_r;

endmodule

// File: tb/tb_ipv4_flow_key_extractor.sv
`timescale 1ns / 1ps
module tb_ipv4_flow_key_extractor;
  import ifke_pkg::*;

  localparam int unsigned OFS_SRC_FIRST = 12;
  localparam int unsigned OFS_SRC_LAST  = 15;
  localparam int unsigned OFS_DST_FIRST = 16;
  localparam int unsigned OFS_DST_LAST  = 19;
  localparam int unsigned RANDOM_BYTES  = 500;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        swap;
    logic [31:0] mark;
    logic [30:0] arrival;
    logic [30:0] route;
  } byte_xfer_t;

  typedef struct packed {
    logic [31:0] mark;
    logic [30:0] ifindex;
    logic [7:0]  protocol;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    logic [7:0]  tos;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] gre_key;
  } flow_key_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        in_swap_direction;
  logic [31:0] in_packet_mark;
  logic [30:0] in_arrival_ifindex;
  logic [30:0] in_route_ifindex;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_key_mark;
  logic [30:0] out_key_ifindex;
  logic [7:0]  out_key_protocol;
  logic [31:0] out_key_dst_addr;
  logic [31:0] out_key_src_addr;
  logic [7:0]  out_key_tos;
  logic [15:0] out_key_src_port;
  logic [15:0] out_key_dst_port;
  logic [7:0]  out_key_icmp_type;
  logic [7:0]  out_key_icmp_code;
  logic [31:0] out_key_gre_key;

  ipv4_flow_key_extractor u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .in_swap_direction (in_swap_direction),
    .in_packet_mark    (in_packet_mark),
    .in_arrival_ifindex(in_arrival_ifindex),
    .in_route_ifindex  (in_route_ifindex),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key_mark      (out_key_mark),
    .out_key_ifindex   (out_key_ifindex),
    .out_key_protocol  (out_key_protocol),
    .out_key_dst_addr  (out_key_dst_addr),
    .out_key_src_addr  (out_key_src_addr),
    .out_key_tos       (out_key_tos),
    .out_key_src_port  (out_key_src_port),
    .out_key_dst_port  (out_key_dst_port),
    .out_key_icmp_type (out_key_icmp_type),
    .out_key_icmp_code (out_key_icmp_code),
    .out_key_gre_key   (out_key_gre_key)
  );

  // Shadow copy of the capture state, advanced on every accepted byte.
  logic [15:0] pkt_count;
  logic [7:0]  hdr_bytes;
  logic [7:0]  cap_tos;
  logic [15:0] cap_frag;
  logic [7:0]  cap_proto;
  logic [31:0] cap_src;
  logic [31:0] cap_dst;
  logic [7:0]  cap_l4 [L4_BYTES];
  logic [31:0] meta_mark;
  logic [30:0] meta_arrival;
  logic [30:0] meta_route;
  logic        meta_swap;

  flow_key_t   expected_keys[$];
  logic [7:0]  pkt_buf[$];
  int unsigned err_count;
  int unsigned bytes_accepted;
  int unsigned hold_off_len;
  bit          idling_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("ipv4_flow_key_extractor test failed");
    $finish;
  end

  task automatic report_error(input string msg);
    err_count++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long one; no gap unless idling_on.
  function automatic int draw_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_capture();
    hdr_bytes  = '0;
    cap_tos    = '0;
    cap_frag   = '0;
    cap_proto  = '0;
    cap_src    = '0;
    cap_dst    = '0;
    for (int i = 0; i < L4_BYTES; i++) cap_l4[i] = '0;
  endtask

  task automatic predict_flow_key(input byte_xfer_t x);
    int unsigned idx;
    int unsigned total;
    int unsigned past;
    logic        rev;
    logic [15:0] word0;
    logic [15:0] word1;
    flow_key_t   k;
    idx = 32'(pkt_count);
    if (x.first) begin
      idx = 0;
      clear_capture();
      meta_mark    = x.mark;
      meta_arrival = x.arrival;
      meta_route   = x.route;
      meta_swap    = x.swap;
    end
    if (idx == 0) begin
      hdr_bytes  = {2'b00, x.data[3:0], 2'b00};
    end else if (idx == OFS_TOS) begin
      cap_tos = x.data;
    end else if (idx == OFS_FRAG_HI) begin
      cap_frag[15:8] = x.data;
    end else if (idx == OFS_FRAG_LO) begin
      cap_frag[7:0] = x.data;
    end else if (idx == OFS_PROTO) begin
      cap_proto = x.data;
    end else if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) begin
      cap_src = {cap_src[23:0], x.data};
    end else if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) begin
      cap_dst = {cap_dst[23:0], x.data};
    end
    // With a small IHL this window overlaps the header bytes above.
    if (idx >= hdr_bytes && idx - hdr_bytes < L4_BYTES) cap_l4[4'(idx - hdr_bytes)] = x.data;
    pkt_count = (idx < COUNT_MAX) ? 16'(idx + 1) : COUNT_MAX;
    if (!x.last) return;

    total = 32'(pkt_count);
    past  = (total >= hdr_bytes) ? total - hdr_bytes : 0;
    rev   = meta_swap;
    word0 = {cap_l4[0], cap_l4[1]};
    word1 = {cap_l4[2], cap_l4[3]};
    k = '0;
    if ((cap_frag & FRAG_MASK) == 16'h0000) begin
      case (cap_proto)
        PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_SCTP, PROTO_UDPLITE: begin
          if (past >= NEED_PORTS) begin
            k.src_port = rev ? word1 : word0;
            k.dst_port = rev ? word0 : word1;
          end
        end
        PROTO_ICMP: begin
          if (past >= NEED_ICMP) begin
            k.icmp_type = cap_l4[0];
            k.icmp_code = cap_l4[1];
          end
        end
        PROTO_GRE: begin
          if (past >= NEED_GRE && cap_l4[0][GRE_KEY_BIT]) begin
            if (cap_l4[0][GRE_CSUM_BIT]) k.gre_key = {cap_l4[8], cap_l4[9], cap_l4[10], cap_l4[11]};
            else k.gre_key = {cap_l4[4], cap_l4[5], cap_l4[6], cap_l4[7]};
          end
        end
        default: ;
      endcase
    end
    k.mark     = meta_mark;
    k.ifindex  = rev ? meta_arrival : meta_route;
    k.protocol = cap_proto;
    k.dst_addr = rev ? cap_src : cap_dst;
    k.src_addr = rev ? cap_dst : cap_src;
    k.tos      = cap_tos & TOS_MASK;
    expected_keys.push_back(k);
    pkt_count = '0;
  endtask

  // Entered and left right after a rising edge; valid drops only during a preceding gap.
  task automatic send_byte(input byte_xfer_t x);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= x.data;
    in_first_byte      <= x.first;
    in_last_byte       <= x.last;
    in_swap_direction  <= x.swap;
    in_packet_mark     <= x.mark;
    in_arrival_ifindex <= x.arrival;
    in_route_ifindex   <= x.route;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_flow_key(x);
    bytes_accepted++;
  endtask

  task automatic build_packet(input int ihl, input logic [7:0] proto, input logic [15:0] frag,
                              input int total_len, input logic [7:0] gre_flags);
    int hdr;
    hdr = ihl * 4;
    pkt_buf.delete();
    repeat (total_len) pkt_buf.push_back(8'($urandom()));
    if (total_len > 0) pkt_buf[0] = {4'h4, 4'(ihl)};
    if (total_len > OFS_FRAG_LO) begin
      pkt_buf[OFS_FRAG_HI] = frag[15:8];
      pkt_buf[OFS_FRAG_LO] = frag[7:0];
    end
    if (total_len > OFS_PROTO) pkt_buf[OFS_PROTO] = proto;
    if (proto == PROTO_GRE && ihl >= 5 && hdr < total_len) pkt_buf[hdr] = gre_flags;
  endtask

  // Metadata on bytes other than the first is random; the block must ignore it.
  task automatic send_packet(input logic swap, input logic [31:0] mark,
                             input logic [30:0] arrival, input logic [30:0] route,
                             input bit with_first, input bit with_last);
    byte_xfer_t x;
    for (int i = 0; i < pkt_buf.size(); i++) begin
      x.data  = pkt_buf[i];
      x.first = with_first && (i == 0);
      x.last  = with_last && (i == pkt_buf.size() - 1);
      if (i == 0) begin
        x.swap    = swap;
        x.mark    = mark;
        x.arrival = arrival;
        x.route   = route;
      end else begin
        x.swap    = 1'($urandom());
        x.mark    = $urandom();
        x.arrival = 31'($urandom());
        x.route   = 31'($urandom());
      end
      send_byte(x);
    end
  endtask

  task automatic send_random_meta(input bit with_first, input bit with_last);
    send_packet(1'($urandom()), $urandom(), 31'($urandom()), 31'($urandom()),
                with_first, with_last);
  endtask

  task automatic send_random_packet();
    int          ihl;
    int          l4_len;
    int          total;
    int          r;
    logic [7:0]  proto;
    logic [7:0]  flags;
    logic [15:0] frag;
    ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
    case ($urandom_range(0, 8))
      0: proto = PROTO_ICMP;
      1: proto = PROTO_TCP;
      2: proto = PROTO_UDP;
      3: proto = PROTO_DCCP;
      4: proto = PROTO_GRE;
      5: proto = PROTO_SCTP;
      6: proto = PROTO_UDPLITE;
      7: proto = PROTO_GRE;
      default: proto = 8'($urandom());
    endcase
    r = $urandom_range(0, 9);
    if (r < 7) frag = 16'h0000;
    else if (r == 7) frag = 16'h4000;
    else frag = 16'($urandom());
    flags = 8'($urandom());
    if ($urandom_range(0, 3) != 0) flags[GRE_KEY_BIT] = 1'b1;
    l4_len = ($urandom_range(0, 3) != 0) ? $urandom_range(8, 16) : $urandom_range(0, 7);
    total = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 24) : ihl * 4 + l4_len;
    if (total == 0) total = 1;
    build_packet(ihl, proto, frag, total, flags);
    send_random_meta($urandom_range(0, 19) != 0, 1'b1);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  // Metadata is still zero from reset, so the key carries zero mark and index.
  task automatic test_no_first_after_reset();
    build_packet(5, PROTO_TCP, 16'h0000, 24, 8'h00);
    send_packet(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b1);
  endtask

  task automatic test_protocols();
    logic [7:0] proto;
    logic [7:0] flags;
    for (int i = 0; i < 10; i++) begin
      flags = 8'h00;
      case (i)
        0: proto = PROTO_TCP;
        1: proto = PROTO_UDP;
        2: proto = PROTO_UDPLITE;
        3: proto = PROTO_SCTP;
        4: proto = PROTO_DCCP;
        5: proto = PROTO_ICMP;
        6: begin proto = PROTO_GRE; flags = 8'h20; end
        7: begin proto = PROTO_GRE; flags = 8'hA0; end
        8: begin proto = PROTO_GRE; flags = 8'h80; end
        default: proto = 8'hFF;
      endcase
      build_packet(5, proto, 16'h0000, 36, flags);
      if (i % 2 == 0) send_packet(1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h0, 1'b1, 1'b1);
      else send_packet(1'b1, 32'h0, 31'h0, 31'h7FFF_FFFF, 1'b1, 1'b1);
    end
  endtask

  task automatic test_fragments();
    logic [15:0] frag;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: frag = 16'h4000;
        1: frag = 16'h2000;
        2: frag = 16'h0001;
        3: frag = 16'hC000;
        default: frag = 16'hFFFF;
      endcase
      build_packet(5, PROTO_TCP, frag, 28, 8'h00);
      send_random_meta(1'b1, 1'b1);
    end
  endtask

  // Lengths straddle the minimum L4 byte count of each kind.
  task automatic test_short_packets();
    build_packet(5, PROTO_TCP, 16'h0000, 23, 8'h00);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_UDP, 16'h0000, 24, 8'h00);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_ICMP, 16'h0000, 21, 8'h00);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_ICMP, 16'h0000, 22, 8'h00);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_GRE, 16'h0000, 31, 8'h20);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_GRE, 16'h0000, 32, 8'hA0);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_TCP, 16'h0000, 14, 8'h00);
    send_random_meta(1'b1, 1'b1);
    build_packet(5, PROTO_TCP, 16'h0000, 5, 8'h00);
    send_random_meta(1'b1, 1'b1);
    // One-byte packets carrying first and last together.
    build_packet(15, 8'h00, 16'h0000, 1, 8'h00);
    pkt_buf[0] = 8'hFF;
    send_random_meta(1'b1, 1'b1);
    pkt_buf[0] = 8'h00;
    send_random_meta(1'b1, 1'b1);
  endtask

  task automatic test_small_ihl();
    for (int ihl = 0; ihl < 5; ihl++) begin
      build_packet(ihl, PROTO_TCP, 16'h0000, 24, 8'h00);
      send_random_meta(1'b1, 1'b1);
      build_packet(ihl, PROTO_ICMP, 16'h0000, 24, 8'h00);
      send_random_meta(1'b1, 1'b1);
    end
    build_packet(15, PROTO_GRE, 16'h0000, 72, 8'h20);
    send_random_meta(1'b1, 1'b1);
  endtask

  task automatic test_restart_and_continuation();
    // A first byte in the middle of a packet starts over.
    build_packet(5, PROTO_TCP, 16'h0000, 10, 8'h00);
    send_random_meta(1'b1, 1'b0);
    build_packet(5, PROTO_TCP, 16'h0000, 30, 8'h00);
    send_random_meta(1'b1, 1'b1);
    // No first byte: the count restarts after the last key and stale fields remain.
    build_packet(5, PROTO_UDP, 16'h0000, 24, 8'h00);
    send_random_meta(1'b0, 1'b1);
    // No first byte after an unfinished packet: the count carries on.
    build_packet(5, PROTO_ICMP, 16'h0000, 8, 8'h00);
    send_random_meta(1'b1, 1'b0);
    build_packet(5, PROTO_ICMP, 16'h0000, 20, 8'h00);
    send_random_meta(1'b0, 1'b1);
  endtask

  // The receiver stops for a long stretch while one-byte packets keep coming.
  task automatic test_output_hold_off();
    idling_on = 1'b0;
    hold_off_len = 400;
    for (int i = 0; i < 16; i++) begin
      build_packet($urandom_range(0, 15), 8'h00, 16'h0000, 1, 8'h00);
      send_random_meta(1'b1, 1'b1);
    end
    idling_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) send_random_packet();
    pause_until_drained();
    repeat (3) send_random_packet();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int          run_len;
    byte_xfer_t  x;
    start = bytes_accepted;
    while (bytes_accepted - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 11) == 0) idling_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // Loose bytes with random framing flags.
        run_len = $urandom_range(1, 20);
        repeat (run_len) begin
          x.data    = 8'($urandom());
          x.first   = ($urandom_range(0, 7) == 0);
          x.last    = ($urandom_range(0, 7) == 0);
          x.swap    = 1'($urandom());
          x.mark    = $urandom();
          x.arrival = 31'($urandom());
          x.route   = 31'($urandom());
          send_byte(x);
        end
      end else begin
        send_random_packet();
      end
    end
    idling_on = 1'b1;
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_keys.size() != 0 && waited < 5000);
    repeat (10) @(posedge clk);
    if (expected_keys.size() != 0)
      report_error($sformatf("%0d flow keys never arrived", expected_keys.size()));
    if (err_count == 0) $display("ipv4_flow_key_extractor test passed");
    else $display("ipv4_flow_key_extractor test failed");
    $finish;
  endtask

  initial begin : drive_out_ready
    int hold_left;
    int seg_left;
    int low;
    bit seg_ready;
    hold_left = 0;
    seg_left  = 0;
    seg_ready = 1'b1;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        hold_left = hold_off_len;
        hold_off_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          low = seg_ready ? draw_gap() : 0;
          seg_ready = (low == 0);
          seg_left = (low == 0) ? $urandom_range(1, 8) : low;
        end
        seg_left--;
        out_ready <= seg_ready;
      end
    end
  end

  initial begin : check_keys
    flow_key_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_keys.size() == 0) begin
          report_error("flow key transfer with no packet pending");
        end else begin
          want = expected_keys.pop_front();
          compare_field("mark", out_key_mark, want.mark);
          compare_field("ifindex", 32'(out_key_ifindex), 32'(want.ifindex));
          compare_field("protocol", 32'(out_key_protocol), 32'(want.protocol));
          compare_field("dst_addr", out_key_dst_addr, want.dst_addr);
          compare_field("src_addr", out_key_src_addr, want.src_addr);
          compare_field("tos", 32'(out_key_tos), 32'(want.tos));
          compare_field("src_port", 32'(out_key_src_port), 32'(want.src_port));
          compare_field("dst_port", 32'(out_key_dst_port), 32'(want.dst_port));
          compare_field("icmp_type", 32'(out_key_icmp_type), 32'(want.icmp_type));
          compare_field("icmp_code", 32'(out_key_icmp_code), 32'(want.icmp_code));
          compare_field("gre_key", out_key_gre_key, want.gre_key);
        end
      end
    end
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data_byte       = '0;
    in_first_byte      = 1'b0;
    in_last_byte       = 1'b0;
    in_swap_direction  = 1'b0;
    in_packet_mark     = '0;
    in_arrival_ifindex = '0;
    in_route_ifindex   = '0;
    err_count          = 0;
    bytes_accepted     = 0;
    hold_off_len       = 0;
    idling_on          = 1'b1;
    pkt_count          = '0;
    clear_capture();
    meta_mark          = '0;
    meta_arrival       = '0;
    meta_route         = '0;
    meta_swap          = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_no_first_after_reset();
    test_protocols();
    test_fragments();
    test_short_packets();
    test_small_ihl();
    test_restart_and_continuation();
    test_output_hold_off();
    test_drain_pause();
    test_random_traffic();
    finish_run();
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ifke_pkg.sv
rtl/ifke_front.sv
rtl/ifke_queue.sv
rtl/ifke_back.sv
rtl/ipv4_flow_key_extractor.sv
tb/tb_ipv4_flow_key_extractor.sv
